@@ rtl/zfre_pkg.sv @@
// shared types and constants for the zero/ff run escape encoder
package zfre_pkg;

  localparam int unsigned MaxBytes  = 5;
  localparam int unsigned NumWidth  = $clog2(MaxBytes + 1);
  localparam int unsigned FifoDepth = 2;

  localparam logic [7:0]  RunByte  = 8'hFF;
  localparam logic [7:0]  ZeroByte = 8'h00;
  localparam logic [7:0]  OnesFlag = 8'h80;
  localparam logic [7:0]  TermByte = 8'h00;
  localparam logic [15:0] LenMax   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  coded_byte;
    logic        burst_end;
    logic        stream_done;
    logic [15:0] coded_length;
  } out_item_t;

  // bytes an item turns into, in emit order
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [NumWidth-1:0]      num;
    logic                     done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

@@ rtl/zero_ff_run_escape_encoder.sv @@
// top level of the zero/ff run escape encoder
//
// input channel: one raw byte per item with is_final on the last byte of a
// buffer; accepted when in_valid_i is high and in_stall_o is low.
// output channel: one coded byte per item, with burst_end on the last byte
// caused by an input item and stream_done plus coded_length on the 0x00
// terminator; taken when out_valid_o is high and out_stall_i is low.
// an input item causes zero to five output bytes. the front end classifies
// a byte in the cycle it is accepted and queues its byte list; the output
// stage sends one byte per cycle from its output register while the
// receiver does not stall. the first byte of an item is written into the
// queue and then loaded into the output register. the queue lets the
// front end accept new items while earlier bytes are still being sent.
// alternating 0x00/0xff input gives two output bytes per item.
// reset clears the run state, the length count, the queue and the output
// valid flag. when the receiver stalls, the output register holds, the
// queue fills and in_stall_o rises once two byte lists are waiting.
module zero_ff_run_escape_encoder #(
  parameter int unsigned MAX_RUN = 127
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  zfre_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output zfre_pkg::out_item_t out_item_o
);

  zfre_pkg::cmd_t         cmd, head;
  zfre_pkg::fifo_status_t status;
  logic                   cmd_valid, pop;

  zfre_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cmd_full_i (status.full),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  zfre_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_valid),
    .push_data_i(cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (status)
  );

  zfre_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .status_i   (status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ rtl/zfre_front.sv @@
// front end: accepts bytes, tracks the open run and builds the byte list per item
module zfre_front #(
  parameter int unsigned MAX_RUN = 127
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  zfre_pkg::in_item_t in_item_i,
  input  logic              cmd_full_i,
  output logic              cmd_valid_o,
  output zfre_pkg::cmd_t    cmd_o
);

  logic       run_open_q, run_open_d;
  logic       run_ones_q, run_ones_d;
  logic [6:0] run_count_q, run_count_d;
  logic       accept;
  logic       is_run_byte;
  logic       byte_ones;
  zfre_pkg::cmd_t cmd;

  assign accept      = in_valid_i && !cmd_full_i;
  assign in_stall_o  = cmd_full_i;
  assign is_run_byte = (in_item_i.raw_byte == zfre_pkg::ZeroByte) ||
                       (in_item_i.raw_byte == zfre_pkg::RunByte);
  assign byte_ones   = (in_item_i.raw_byte == zfre_pkg::RunByte);

  always_comb begin
    cmd         = '0;
    run_open_d  = run_open_q;
    run_ones_d  = run_ones_q;
    run_count_d = run_count_q;

    if (is_run_byte) begin
      // value change closes the open run
      if (run_open_d && (run_ones_d != byte_ones)) begin
        cmd.bytes[cmd.num] = zfre_pkg::RunByte;
        cmd.num = cmd.num + 1'b1;
        cmd.bytes[cmd.num] = (run_ones_d ? zfre_pkg::OnesFlag : 8'h00) | {1'b0, run_count_d};
        cmd.num = cmd.num + 1'b1;
        run_open_d  = 1'b0;
        run_ones_d  = 1'b0;
        run_count_d = '0;
      end
      if (!run_open_d) begin
        run_open_d  = 1'b1;
        run_ones_d  = byte_ones;
        run_count_d = '0;
      end
      run_count_d = run_count_d + 7'd1;
      if (run_count_d >= 7'(MAX_RUN)) begin
        cmd.bytes[cmd.num] = zfre_pkg::RunByte;
        cmd.num = cmd.num + 1'b1;
        cmd.bytes[cmd.num] = (run_ones_d ? zfre_pkg::OnesFlag : 8'h00) | {1'b0, run_count_d};
        cmd.num = cmd.num + 1'b1;
        run_open_d  = 1'b0;
        run_ones_d  = 1'b0;
        run_count_d = '0;
      end
    end else begin
      if (run_open_d) begin
        cmd.bytes[cmd.num] = zfre_pkg::RunByte;
        cmd.num = cmd.num + 1'b1;
        cmd.bytes[cmd.num] = (run_ones_d ? zfre_pkg::OnesFlag : 8'h00) | {1'b0, run_count_d};
        cmd.num = cmd.num + 1'b1;
      end
      run_open_d  = 1'b0;
      run_ones_d  = 1'b0;
      run_count_d = '0;
      cmd.bytes[cmd.num] = in_item_i.raw_byte;
      cmd.num = cmd.num + 1'b1;
    end

    if (in_item_i.is_final) begin
      if (run_open_d) begin
        cmd.bytes[cmd.num] = zfre_pkg::RunByte;
        cmd.num = cmd.num + 1'b1;
        cmd.bytes[cmd.num] = (run_ones_d ? zfre_pkg::OnesFlag : 8'h00) | {1'b0, run_count_d};
        cmd.num = cmd.num + 1'b1;
      end
      cmd.bytes[cmd.num] = zfre_pkg::TermByte;
      cmd.num  = cmd.num + 1'b1;
      cmd.done = 1'b1;
      run_open_d  = 1'b0;
      run_ones_d  = 1'b0;
      run_count_d = '0;
    end
  end

  assign cmd_valid_o = accept && (cmd.num != '0);
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q  <= 1'b0;
      run_ones_q  <= 1'b0;
      run_count_q <= '0;
    end else if (accept) begin
      run_open_q  <= run_open_d;
      run_ones_q  <= run_ones_d;
      run_count_q <= run_count_d;
    end
  end

endmodule

@@ rtl/zfre_fifo.sv @@
// short command queue between front end and output stage
module zfre_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  zfre_pkg::cmd_t        push_data_i,
  input  logic                  pop_i,
  output zfre_pkg::cmd_t        head_o,
  output zfre_pkg::fifo_status_t status_o
);

  localparam int unsigned PtrWidth = (zfre_pkg::FifoDepth > 1) ?
                                     $clog2(zfre_pkg::FifoDepth) : 1;
  localparam int unsigned CntWidth = $clog2(zfre_pkg::FifoDepth + 1);

  zfre_pkg::cmd_t        mem_q [zfre_pkg::FifoDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]   count_q;
  logic                  do_push, do_pop;

  assign status_o.full  = (count_q == CntWidth'(zfre_pkg::FifoDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(zfre_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(zfre_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/zfre_back.sv @@
// output stage: emits queued bytes one per cycle unless stalled and counts the buffer length
module zfre_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  zfre_pkg::cmd_t         head_i,
  input  zfre_pkg::fifo_status_t status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output zfre_pkg::out_item_t    out_item_o
);

  logic [zfre_pkg::NumWidth-1:0] idx_q;
  logic [15:0]                   count_q;
  logic [15:0]                   count_inc;
  logic                          out_valid_q;
  zfre_pkg::out_item_t           out_q;
  logic                          load, take, last;

  assign load      = !out_valid_q || !out_stall_i;
  assign take      = load && !status_i.empty;
  assign last      = (idx_q == head_i.num - 1'b1);
  assign pop_o     = take && last;
  assign count_inc = (count_q == zfre_pkg::LenMax) ? count_q : count_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
    end else begin
      if (load) begin
        out_valid_q <= !status_i.empty;
      end
      if (take) begin
        idx_q   <= last ? '0 : idx_q + 1'b1;
        count_q <= (last && head_i.done) ? '0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.coded_byte   <= head_i.bytes[idx_q];
      out_q.burst_end    <= last;
      out_q.stream_done  <= last && head_i.done;
      out_q.coded_length <= (last && head_i.done) ? count_inc : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ tb/tb_zero_ff_run_escape_encoder.sv @@
// testbench for the zero/ff run escape encoder with random and directed byte buffers
`timescale 1ns / 100ps

class escape_scoreboard;
  zfre_pkg::out_item_t coded_q[$];
  bit         run_open;
  bit         run_ones;
  logic [6:0] run_len;
  logic [15:0] byte_count;
  int         errors;
  int         inputs_seen;
  int         results_seen;
  int         buffers_seen;

  function new();
    clear_state();
    errors = 0;
    inputs_seen = 0;
    results_seen = 0;
    buffers_seen = 0;
  endfunction

  function void clear_state();
    run_open = 1'b0;
    run_ones = 1'b0;
    run_len = '0;
    byte_count = '0;
  endfunction

  function void push_byte(ref zfre_pkg::out_item_t step_q[$], input logic [7:0] b,
                          input bit done);
    zfre_pkg::out_item_t o;
    if (byte_count != zfre_pkg::LenMax) byte_count = byte_count + 16'd1;
    o.coded_byte   = b;
    o.burst_end    = 1'b0;
    o.stream_done  = done;
    o.coded_length = done ? byte_count : 16'd0;
    step_q.push_back(o);
  endfunction

  function void flush_run(ref zfre_pkg::out_item_t step_q[$]);
    if (run_open) begin
      push_byte(step_q, zfre_pkg::RunByte, 1'b0);
      push_byte(step_q, (run_ones ? zfre_pkg::OnesFlag : zfre_pkg::ZeroByte) |
                        {1'b0, run_len}, 1'b0);
    end
    run_open = 1'b0;
    run_ones = 1'b0;
    run_len = '0;
  endfunction

  // work out the bytes an accepted item causes
  function void note_input(zfre_pkg::in_item_t it);
    zfre_pkg::out_item_t step_q[$];
    bit ones;
    inputs_seen++;
    if (it.raw_byte == zfre_pkg::ZeroByte || it.raw_byte == zfre_pkg::RunByte) begin
      ones = (it.raw_byte == zfre_pkg::RunByte);
      if (run_open && run_ones != ones) flush_run(step_q);
      if (!run_open) begin
        run_open = 1'b1;
        run_ones = ones;
        run_len = '0;
      end
      run_len = run_len + 7'd1;
      if (run_len >= 7'd127) flush_run(step_q);
    end else begin
      flush_run(step_q);
      push_byte(step_q, it.raw_byte, 1'b0);
    end
    if (it.is_final) begin
      flush_run(step_q);
      push_byte(step_q, zfre_pkg::TermByte, 1'b1);
      clear_state();
      buffers_seen++;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].burst_end = 1'b1;
    foreach (step_q[i]) coded_q.push_back(step_q[i]);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task check_result(zfre_pkg::out_item_t got);
    zfre_pkg::out_item_t want;
    results_seen++;
    if (coded_q.size() == 0) begin
      report("unexpected item, coded_byte", got.coded_byte, 0);
    end else begin
      want = coded_q.pop_front();
      if (got.coded_byte != want.coded_byte)
        report("coded_byte", got.coded_byte, want.coded_byte);
      if (got.burst_end != want.burst_end)
        report("burst_end", got.burst_end, want.burst_end);
      if (got.stream_done != want.stream_done)
        report("stream_done", got.stream_done, want.stream_done);
      if (got.coded_length != want.coded_length)
        report("coded_length", got.coded_length, want.coded_length);
    end
  endtask
endclass

module tb_zero_ff_run_escape_encoder;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  zfre_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  zfre_pkg::out_item_t out_item;
  bit                  no_idle = 1'b0;

  escape_scoreboard sb = new();

  zero_ff_run_escape_encoder #(.MAX_RUN(127)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 6);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic fin);
    zfre_pkg::in_item_t it;
    it.raw_byte = b;
    it.is_final = fin;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic send_run(input logic [7:0] b, input int n, input logic fin);
    for (int i = 0; i < n; i++) send_item(b, fin && (i == n - 1));
  endtask

  // buffers of runs and plain bytes, most short, a few long runs
  task automatic send_random_buffer(input int len, ref int sent);
    int left;
    int seg;
    bit plain;
    logic [7:0] b;
    left = len;
    while (left > 0) begin
      plain = ($urandom_range(0, 9) < 5);
      b = $urandom_range(0, 1) ? zfre_pkg::RunByte : zfre_pkg::ZeroByte;
      if (plain) seg = $urandom_range(1, 4);
      else if ($urandom_range(0, 29) == 0) seg = $urandom_range(124, 131);
      else seg = $urandom_range(1, 6);
      if (seg > left) seg = left;
      repeat (seg) begin
        if (plain) b = $urandom_range(0, 255);
        left--;
        sent++;
        send_item(b, left == 0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_item);
    out_stall <= idle_now();
  end

  initial begin
    #8ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain bytes at the edges of the run values
    send_item(8'h01, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFE, 1'b0);
    // run broken by a plain byte, then by the other run value
    send_item(8'h00, 1'b0);
    send_item(8'h55, 1'b0);
    send_run(8'hFF, 2, 1'b0);
    send_run(8'h00, 3, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h12, 1'b1);
    // one-byte buffers
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'hC3, 1'b1);
    // final byte breaking a run, after a one-byte run and after a two-byte run
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_run(8'h00, 2, 1'b0);
    send_item(8'hFF, 1'b1);

    // runs at the length limit and just past it, with no idling
    no_idle = 1'b1;
    send_run(8'h00, 127, 1'b0);
    send_run(8'hFF, 128, 1'b1);
    no_idle = 1'b0;

    sent = 0;
    while (sent < 90) send_random_buffer($urandom_range(1, 24), sent);
    in_valid <= 1'b0;

    while (sb.coded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d input items in %0d buffers, %0d coded bytes checked",
             sb.inputs_seen, sb.buffers_seen, sb.results_seen);
    $display("covered runs at the limit, run breaks, one-byte buffers and random stalls");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ zero_ff_run_escape_encoder.f @@
rtl/zfre_pkg.sv
rtl/zfre_front.sv
rtl/zfre_fifo.sv
rtl/zfre_back.sv
rtl/zero_ff_run_escape_encoder.sv
tb/tb_zero_ff_run_escape_encoder.sv
